/* rtl/ght_pkg.sv */
`timescale 1ns / 1ps
// shared package for the generational handle table
// operation and status codes, default sizes, controller command type
package ght_pkg;

   localparam int SLOTS_DEFAULT        = 4096;
   localparam int GEN_BITS_DEFAULT     = 15;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 5;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_GET    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
   } ght_cmd_type;

   function automatic int byte_round(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

/* rtl/ght_ctrl.sv */
`timescale 1ns / 1ps
// request sequencer: capture, then execute once the response register is free
// depends on ght_pkg
module ght_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output ght_pkg::ght_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_tvalid;
      cmd.execute = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/ght_datapath.sv */
`timescale 1ns / 1ps
// slot memory, free list head, live count, fill mark and response register
// depends on ght_pkg; driven by ght_ctrl commands
module ght_datapath #(
   parameter int SLOTS        = ght_pkg::SLOTS_DEFAULT,
   parameter int GEN_BITS     = ght_pkg::GEN_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEFAULT,
   localparam int IDX_W       = $clog2(SLOTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ght_pkg::ght_cmd_type          cmd,
   input  logic [ght_pkg::OP_W-1:0]      req_op,
   input  logic [IDX_W-1:0]              req_index,
   input  logic [GEN_BITS-1:0]           req_generation,
   input  logic [ght_pkg::KIND_W-1:0]    req_kind,
   input  logic [PAYLOAD_BITS-1:0]       req_payload,
   output logic [ght_pkg::STATUS_W-1:0]  rsp_status,
   output logic [IDX_W-1:0]              rsp_index,
   output logic [GEN_BITS-1:0]           rsp_generation,
   output logic [ght_pkg::KIND_W-1:0]    rsp_kind,
   output logic [PAYLOAD_BITS-1:0]       rsp_payload
);

   // memory word: payload, live, generation, next free (lowest)
   localparam int GEN_LO  = IDX_W;
   localparam int LIVE_B  = IDX_W + GEN_BITS;
   localparam int PAY_LO  = LIVE_B + 1;
   localparam int WORD_W  = PAY_LO + PAYLOAD_BITS;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

   logic [WORD_W-1:0] slot_mem [SLOTS];

   logic [ght_pkg::OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]           addr_ff;
   logic [GEN_BITS-1:0]        gen_ff;
   logic [ght_pkg::KIND_W-1:0] kind_ff;
   logic [PAYLOAD_BITS-1:0]    pay_ff;
   logic                       in_range_ff;
   logic                       fresh_ff;
   logic [WORD_W-1:0]          rd_ff;

   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W-1:0] live_count_ff, live_count_in;
   logic [IDX_W-1:0] fill_ff, fill_in;

   logic [ght_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]             index_ff, index_in;
   logic [GEN_BITS-1:0]          ogen_ff, ogen_in;
   logic [ght_pkg::KIND_W-1:0]   okind_ff, okind_in;
   logic [PAYLOAD_BITS-1:0]      opay_ff, opay_in;

   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    cur_next;
   logic [GEN_BITS-1:0] cur_gen;
   logic                cur_live;
   logic [GEN_BITS-1:0] bumped_gen;
   logic                wr_en;
   logic [WORD_W-1:0]   wr_word;

   assign rd_addr = (req_op == ght_pkg::OP_ADD) ? free_head_ff : req_index;

   // slots at or above the fill mark were never handed out and read as free, gen 1
   always_comb begin
      if (fresh_ff) begin
         cur_next = addr_ff + IDX_W'(1);
         cur_gen  = GEN_BITS'(1);
         cur_live = 1'b0;
      end else begin
         cur_next = rd_ff[IDX_W-1:0];
         cur_gen  = rd_ff[LIVE_B-1:GEN_LO];
         cur_live = rd_ff[LIVE_B];
      end
      bumped_gen = cur_gen + GEN_BITS'(1);
      if (bumped_gen == '0) begin
         bumped_gen = GEN_BITS'(1);
      end
   end

   always_comb begin
      free_head_in  = free_head_ff;
      live_count_in = live_count_ff;
      fill_in       = fill_ff;
      wr_en         = 1'b0;
      wr_word       = rd_ff;
      status_in     = ght_pkg::ST_OK;
      index_in      = '0;
      ogen_in       = '0;
      okind_in      = '0;
      opay_in       = '0;
      if (op_ff == ght_pkg::OP_ADD) begin
         if (free_head_ff >= LAST_SLOT || live_count_ff >= LAST_SLOT || cur_live) begin
            status_in = ght_pkg::ST_FULL;
         end else begin
            wr_en         = 1'b1;
            wr_word       = {pay_ff, 1'b1, bumped_gen, {IDX_W{1'b0}}};
            free_head_in  = cur_next;
            live_count_in = live_count_ff + IDX_W'(1);
            if (fresh_ff) begin
               fill_in = fill_ff + IDX_W'(1);
            end
            index_in = addr_ff;
            ogen_in  = bumped_gen;
            okind_in = kind_ff;
         end
      end else if (!in_range_ff || !cur_live || cur_gen != gen_ff) begin
         status_in = ght_pkg::ST_STALE;
      end else begin
         case (op_ff)
            ght_pkg::OP_UPDATE: begin
               wr_en   = 1'b1;
               wr_word = {pay_ff, rd_ff[LIVE_B:0]};
            end
            ght_pkg::OP_REMOVE: begin
               wr_en        = 1'b1;
               wr_word      = {rd_ff[WORD_W-1:PAY_LO], 1'b0, cur_gen, free_head_ff};
               free_head_in = addr_ff;
               if (live_count_ff != '0) begin
                  live_count_in = live_count_ff - IDX_W'(1);
               end
            end
            ght_pkg::OP_GET: begin
               opay_in = rd_ff[WORD_W-1:PAY_LO];
            end
            default: status_in = ght_pkg::ST_STALE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= slot_mem[rd_addr];
      end
      if (cmd.execute && wr_en) begin
         slot_mem[addr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_op;
         addr_ff     <= rd_addr;
         gen_ff      <= req_generation;
         kind_ff     <= req_kind;
         pay_ff      <= req_payload;
         in_range_ff <= ({1'b0, req_index} < (IDX_W + 1)'(SLOTS));
         fresh_ff    <= (rd_addr >= fill_ff);
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         ogen_ff   <= ogen_in;
         okind_ff  <= okind_in;
         opay_ff   <= opay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         live_count_ff <= '0;
         fill_ff       <= '0;
      end else if (cmd.execute) begin
         free_head_ff  <= free_head_in;
         live_count_ff <= live_count_in;
         fill_ff       <= fill_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_index      = index_ff;
   assign rsp_generation = ogen_ff;
   assign rsp_kind       = okind_ff;
   assign rsp_payload    = opay_ff;

endmodule

/* rtl/generational_handle_table.sv */
`timescale 1ns / 1ps
// generational handle table top level: stream ports, field packing
// depends on ght_pkg, ght_ctrl, ght_datapath
//
//  group  | dir | tdata (low bit up)                           | tuser
//  req_   | in  | handle_index, handle_generation, handle_kind, | op
//         |     | payload_in, zero fill                        |
//  rsp_   | out | out_index, out_generation, out_kind,          | status
//         |     | payload_out, zero fill                       |
//
// each request does one slot memory read at capture, then at most one write at execute on the same port
// a new request is taken while the previous response still waits in its register
// the execute cycle waits while an earlier response is still held by rsp_tready low
// reset is immediate: a fill mark stands in for the free list linking, no clearing pass
module generational_handle_table #(
   parameter int SLOTS        = ght_pkg::SLOTS_DEFAULT,
   parameter int GEN_BITS     = ght_pkg::GEN_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEFAULT,
   localparam int IDX_W       = $clog2(SLOTS),
   localparam int FIELD_W     = IDX_W + GEN_BITS + ght_pkg::KIND_W + PAYLOAD_BITS,
   localparam int DATA_W      = ght_pkg::byte_round(FIELD_W)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [DATA_W-1:0]            req_tdata,  // handle_index, handle_generation, handle_kind, payload_in
   input  logic [ght_pkg::OP_W-1:0]     req_tuser,  // op
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [DATA_W-1:0]            rsp_tdata,  // out_index, out_generation, out_kind, payload_out
   output logic [ght_pkg::STATUS_W-1:0] rsp_tuser   // status
);

   localparam int GEN_LO  = IDX_W;
   localparam int KIND_LO = GEN_LO + GEN_BITS;
   localparam int PAY_LO  = KIND_LO + ght_pkg::KIND_W;

   ght_pkg::ght_cmd_type       cmd;
   logic [IDX_W-1:0]           out_index;
   logic [GEN_BITS-1:0]        out_generation;
   logic [ght_pkg::KIND_W-1:0] out_kind;
   logic [PAYLOAD_BITS-1:0]    payload_out;

   ght_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ght_datapath #(
      .SLOTS        (SLOTS),
      .GEN_BITS     (GEN_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_tuser),
      .req_index      (req_tdata[IDX_W-1:0]),
      .req_generation (req_tdata[KIND_LO-1:GEN_LO]),
      .req_kind       (req_tdata[PAY_LO-1:KIND_LO]),
      .req_payload    (req_tdata[FIELD_W-1:PAY_LO]),
      .rsp_status     (rsp_tuser),
      .rsp_index      (out_index),
      .rsp_generation (out_generation),
      .rsp_kind       (out_kind),
      .rsp_payload    (payload_out)
   );

   assign rsp_tdata = DATA_W'({payload_out, out_kind, out_generation, out_index});

endmodule

/* rtl/ght_checker.sv */
`timescale 1ns / 1ps
// port level checks for the generational handle table, bound to the top level
// depends on ght_pkg
module ght_checker #(
   parameter int SLOTS        = ght_pkg::SLOTS_DEFAULT,
   parameter int GEN_BITS     = ght_pkg::GEN_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEFAULT,
   localparam int DATA_W      = ght_pkg::byte_round($clog2(SLOTS) + GEN_BITS
                                                    + ght_pkg::KIND_W + PAYLOAD_BITS)
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [DATA_W-1:0]            rsp_tdata,
   input logic [ght_pkg::STATUS_W-1:0] rsp_tuser
);

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // failed requests return an all-zero handle and payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ght_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("failed request returned data");

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // response follows once the output register is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("response missing after transfer");

endmodule

bind generational_handle_table ght_checker #(
   .SLOTS        (SLOTS),
   .GEN_BITS     (GEN_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_ght_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
